// File: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, skipped while reset is asserted
`define WEPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds across reset
`define WEPC_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/wepc_pkg.sv
// shared constants, types and helpers of the window exact pair counter
// no dependencies
package wepc_pkg;

    localparam int ARRAY_DEPTH = 1024;
    localparam int VALUE_COUNT = 1024;

    localparam int POS_W      = 11;
    localparam int VAL_W      = 10;
    localparam int PAIR_W     = 10;
    localparam int ADDR_W     = $clog2(ARRAY_DEPTH);
    localparam int CNT_ADDR_W = $clog2(VALUE_COUNT);
    localparam int CNT_W      = $clog2(ARRAY_DEPTH + 1);

    localparam int EXACT_COUNT = 2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        DIR_OUT = 1'b0,
        DIR_IN  = 1'b1
    } cnt_dir_t;

    typedef struct packed {
        logic                  valid;
        cnt_dir_t              dir;
        logic [CNT_ADDR_W-1:0] addr;
    } cnt_req_t;

    typedef struct packed {
        logic              busy;
        logic [PAIR_W-1:0] total;
    } cnt_stat_t;

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        r = p;
        if (p == '0) begin
            r = POS_W'(1);
        end else if (int'(p) > ARRAY_DEPTH) begin
            r = POS_W'(ARRAY_DEPTH);
        end
        return r;
    endfunction

endpackage

// File: design/window_exact_pair_counter.sv
// top level: value store, window sequencer and result register
// depends on wepc_pkg and wepc_count_unit
//
// channel | dir | tdata                                         | tuser
// s_      | in  | position, value_id, left_bound, right_bound   | op
// m_      | out | pair_count                                    | range_error
//
// load outside the window: value store write only; load inside the window: ST_LD_OLD, ST_LD_NEW
// query: ST_WALK, ST_DONE (straight to ST_DONE for a reversed range), plus ST_WALK, ST_VAL, ST_CNT
//   per element entering or leaving, for the value store read, count read and count write-back
// after reset a clearing pass zeroes all VALUE_COUNT entries of the count memory,
//   s_tready stays low meanwhile
// loads are taken while a result waits on m_; a query completes once m_ is free
module window_exact_pair_counter import wepc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // position, value_id, left_bound, right_bound
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pair_count
    output logic [0:0]  m_tuser    // range_error
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_VAL,
        ST_CNT,
        ST_LD_OLD,
        ST_LD_NEW,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [POS_W-1:0]  wl_reg;
    logic [POS_W-1:0]  wr_reg;
    logic [POS_W-1:0]  ql_reg;
    logic [POS_W-1:0]  qr_reg;
    logic [VAL_W-1:0]  ld_val_reg;
    cnt_dir_t          dir_reg;
    logic [PAIR_W-1:0] res_pair_reg;
    logic              res_err_reg;
    logic              m_tvalid_reg;
    logic [PAIR_W-1:0] m_pair_reg;
    logic              m_err_reg;

    logic [VAL_W-1:0]  vs_mem [ARRAY_DEPTH];
    logic [VAL_W-1:0]  vs_rdata_reg;
    logic              vs_we;
    logic              vs_re;
    logic [ADDR_W-1:0] vs_raddr;

    cnt_req_t  cnt_req;
    cnt_stat_t cnt_stat;

    op_t              in_op;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [POS_W-1:0] cl;
    logic [POS_W-1:0] cr;
    logic             accept;
    logic             ld_ok;
    logic             in_win;
    logic             out_free;

    logic             step_valid;
    logic [POS_W-1:0] step_pos;
    cnt_dir_t         step_dir;
    logic [POS_W-1:0] wl_step;
    logic [POS_W-1:0] wr_step;

    assign in_op  = op_t'(s_tuser[0]);
    assign in_pos = s_tdata[10:0];
    assign in_val = s_tdata[20:11];
    assign cl     = clamp_pos(s_tdata[31:21]);
    assign cr     = clamp_pos(s_tdata[42:32]);

    assign s_tready = (state_reg == ST_IDLE) && !cnt_stat.busy;
    assign accept   = s_tvalid && s_tready;
    assign ld_ok    = (in_pos != '0) && (int'(in_pos) <= ARRAY_DEPTH)
                   && (int'(in_val) < VALUE_COUNT);
    assign in_win   = (in_pos >= wl_reg) && (in_pos <= wr_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // next window edge move: grow left, grow right, shrink left, shrink right
    always_comb begin
        step_valid = 1'b1;
        step_pos   = wl_reg;
        step_dir   = DIR_IN;
        wl_step    = wl_reg;
        wr_step    = wr_reg;
        priority if (wl_reg > ql_reg) begin
            step_pos = wl_reg - POS_W'(1);
            wl_step  = wl_reg - POS_W'(1);
        end else if (wr_reg < qr_reg) begin
            step_pos = wr_reg + POS_W'(1);
            wr_step  = wr_reg + POS_W'(1);
        end else if (wl_reg < ql_reg) begin
            step_pos = wl_reg;
            step_dir = DIR_OUT;
            wl_step  = wl_reg + POS_W'(1);
        end else if (wr_reg > qr_reg) begin
            step_pos = wr_reg;
            step_dir = DIR_OUT;
            wr_step  = wr_reg - POS_W'(1);
        end else begin
            step_valid = 1'b0;
        end
    end

    always_comb begin
        vs_we    = accept && (in_op == OP_LOAD) && ld_ok;
        vs_re    = 1'b0;
        vs_raddr = ADDR_W'(in_pos - POS_W'(1));
        if (state_reg == ST_WALK) begin
            vs_re    = step_valid;
            vs_raddr = ADDR_W'(step_pos - POS_W'(1));
        end else begin
            vs_re    = vs_we && in_win;
        end
    end

    // read-first: a load in the window reads the old value while writing the new
    always_ff @(posedge aclk) begin
        if (vs_re) begin
            vs_rdata_reg <= vs_mem[vs_raddr];
        end
        if (vs_we) begin
            vs_mem[ADDR_W'(in_pos - POS_W'(1))] <= in_val;
        end
    end

    always_comb begin
        cnt_req.valid = 1'b0;
        cnt_req.dir   = dir_reg;
        cnt_req.addr  = CNT_ADDR_W'(vs_rdata_reg);
        unique case (state_reg)
            ST_VAL: begin
                cnt_req.valid = 1'b1;
            end
            ST_LD_OLD: begin
                cnt_req.valid = 1'b1;
                cnt_req.dir   = DIR_OUT;
            end
            ST_LD_NEW: begin
                cnt_req.valid = 1'b1;
                cnt_req.dir   = DIR_IN;
                cnt_req.addr  = CNT_ADDR_W'(ld_val_reg);
            end
            default: begin
                cnt_req.valid = 1'b0;
            end
        endcase
    end

    wepc_count_unit u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cnt_req),
        .stat    (cnt_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wl_reg       <= POS_W'(1);
            wr_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_pair_reg   <= res_pair_reg;
                m_err_reg    <= res_err_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (in_op == OP_QUERY) begin
                            ql_reg <= cl;
                            qr_reg <= cr;
                            if (cr < cl) begin
                                res_pair_reg <= '0;
                                res_err_reg  <= 1'b1;
                                state_reg    <= ST_DONE;
                            end else begin
                                state_reg <= ST_WALK;
                            end
                        end else if (ld_ok && in_win) begin
                            ld_val_reg <= in_val;
                            state_reg  <= ST_LD_OLD;
                        end
                    end
                end
                ST_WALK: begin
                    if (step_valid) begin
                        wl_reg    <= wl_step;
                        wr_reg    <= wr_step;
                        dir_reg   <= step_dir;
                        state_reg <= ST_VAL;
                    end else begin
                        res_pair_reg <= cnt_stat.total;
                        res_err_reg  <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_VAL: begin
                    state_reg <= ST_CNT;
                end
                ST_CNT: begin
                    state_reg <= ST_WALK;
                end
                ST_LD_OLD: begin
                    state_reg <= ST_LD_NEW;
                end
                ST_LD_NEW: begin
                    state_reg <= ST_IDLE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(16 - PAIR_W)'(0), m_pair_reg};
    assign m_tuser  = m_err_reg;

endmodule

// File: design/wepc_count_unit.sv
// occurrence count memory with clearing pass, read-modify-write and exact-two total
// depends on wepc_pkg
module wepc_count_unit import wepc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cnt_req_t  req,
    output cnt_stat_t stat
);

    logic [CNT_W-1:0] cnt_mem [VALUE_COUNT];

    logic                  clr_active_reg;
    logic [CNT_ADDR_W-1:0] clr_idx_reg;
    logic                  pend_valid_reg;
    cnt_dir_t              pend_dir_reg;
    logic [CNT_ADDR_W-1:0] pend_addr_reg;
    logic [CNT_W-1:0]      rdata_reg;
    logic                  fwd_hit_reg;
    logic [CNT_W-1:0]      fwd_data_reg;
    logic [PAIR_W-1:0]     total_reg;
    logic [PAIR_W-1:0]     total_next;

    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      new_cnt;
    logic                  apply_we;
    logic                  mem_we;
    logic [CNT_ADDR_W-1:0] mem_waddr;
    logic [CNT_W-1:0]      mem_wdata;

    assign cur_cnt = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    always_comb begin
        new_cnt    = cur_cnt;
        apply_we   = 1'b0;
        total_next = total_reg;
        if (pend_valid_reg) begin
            if (pend_dir_reg == DIR_IN) begin
                new_cnt  = cur_cnt + CNT_W'(1);
                apply_we = 1'b1;
            end else if (cur_cnt != '0) begin
                new_cnt  = cur_cnt - CNT_W'(1);
                apply_we = 1'b1;
            end
        end
        if (apply_we) begin
            total_next = total_reg - PAIR_W'(cur_cnt == CNT_W'(EXACT_COUNT))
                                   + PAIR_W'(new_cnt == CNT_W'(EXACT_COUNT));
        end
    end

    assign mem_we    = clr_active_reg | apply_we;
    assign mem_waddr = clr_active_reg ? clr_idx_reg : pend_addr_reg;
    assign mem_wdata = clr_active_reg ? '0 : new_cnt;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        if (req.valid) begin
            rdata_reg <= cnt_mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            total_reg      <= '0;
        end else begin
            if (clr_active_reg) begin
                clr_idx_reg <= clr_idx_reg + CNT_ADDR_W'(1);
                if (clr_idx_reg == CNT_ADDR_W'(VALUE_COUNT - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            pend_valid_reg <= req.valid;
            // read of the entry being written this cycle takes the new count
            fwd_hit_reg    <= req.valid && apply_we && (req.addr == pend_addr_reg);
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_dir_reg  <= req.dir;
        pend_addr_reg <= req.addr;
        fwd_data_reg  <= new_cnt;
    end

    assign stat.busy  = clr_active_reg;
    assign stat.total = total_reg;

endmodule

// File: design/wepc_checker.sv
// port-level checks of the window exact pair counter, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module wepc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `WEPC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `WEPC_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `WEPC_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata[9:0] == 10'd0, "rejected range with nonzero count")
    `WEPC_ASSERT(a_pair_max, aclk, aresetn, m_tvalid |-> m_tdata[9:0] <= 10'd512 && m_tdata[15:10] == 6'd0, "pair count out of range")
    `WEPC_ASSERT_ANY(a_clear_blocks, aclk, !aresetn |=> !s_tready, "transaction taken during clearing pass")

endmodule

bind window_exact_pair_counter wepc_checker u_wepc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
